// File: rtl/sequence_of_events_recorder_core_macros.svh
// Assertion macros shared by the sequence-of-events recorder RTL.
`ifndef SEQUENCE_OF_EVENTS_RECORDER_CORE_MACROS_SVH
`define SEQUENCE_OF_EVENTS_RECORDER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SOER_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SOER_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/soer_pkg.sv
// Package with constants and types of the sequence-of-events recorder.
`default_nettype none

package soer_pkg;

    localparam int NUM_INPUTS    = 8;
    localparam int HISTORY_DEPTH = 64;
    localparam int TIME_BITS     = 48;

    // Fixed field widths of the item and result channels.
    localparam int MODE_W      = 2;
    localparam int LEVEL_W     = 8;
    localparam int STAMP_W     = 48;
    localparam int OFFSET_W    = 6;
    localparam int REMOVE_W    = 7;
    localparam int EV_IN_W     = 3;
    localparam int NEW_W       = 4;
    localparam int COUNT_OUT_W = 7;

    // Only inputs below both NUM_INPUTS and the level field width are watched.
    localparam int SCAN_N = (NUM_INPUTS < LEVEL_W) ? NUM_INPUTS : LEVEL_W;
    localparam int IDX_W  = (SCAN_N > 1) ? $clog2(SCAN_N) : 1;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    // Shared adder width: widest unsigned operand plus a sign bit.
    localparam int AW    = ((CNT_W > REMOVE_W) ? CNT_W : REMOVE_W) + 1;

    // Item modes.
    localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    // Register port.
    localparam int PADDR_W = 2;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-1:0] REG_MASK_ADDR = 2'd0;

    typedef struct packed {
        logic [EV_IN_W-1:0]   input_idx;
        logic                 rising;
        logic [TIME_BITS-1:0] stamp;
    } soer_entry_t;

    typedef struct packed {
        logic                 we;
        logic [PTR_W-1:0]     addr;
        soer_entry_t          data;
    } soer_mem_wr_t;

    typedef struct packed {
        logic                   event_valid;
        logic [EV_IN_W-1:0]     event_input;
        logic                   event_rising;
        logic [STAMP_W-1:0]     event_time;
        logic [NEW_W-1:0]       new_events;
        logic [COUNT_OUT_W-1:0] logged_count;
        logic                   log_full;
    } soer_result_t;

    typedef struct packed {
        logic idle;
        logic done;
    } soer_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RD_CMP,
        ST_RD_ADD,
        ST_RD_WRAP,
        ST_RD_MEM,
        ST_REMOVE,
        ST_DONE
    } soer_state_t;

endpackage

`default_nettype wire

// File: rtl/sequence_of_events_recorder_core.sv
// Sample item: the watched inputs are scanned one per cycle; read item: compare offset with
//   count, and if the entry exists add, wrap and read memory; remove item: one subtract step.
// The sequencer and its single adder serve one item at a time; an unused mode goes to done.
// The next item is accepted while the previous result waits in the output register.
// Reset (rst_n low, asynchronous): last levels, write pointer, count and mask go to zero;
//   the log memory is not cleared, entries are valid only once written.
`default_nettype none

`include "sequence_of_events_recorder_core_macros.svh"

module sequence_of_events_recorder_core
    import soer_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    // Register port
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic [PDATA_W-1:0]          prdata,
    output logic                        pready,

    // Item channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [MODE_W-1:0]      mode,
    input  wire logic [LEVEL_W-1:0]     input_levels,
    input  wire logic [STAMP_W-1:0]     timestamp,
    input  wire logic [OFFSET_W-1:0]    read_offset,
    input  wire logic [REMOVE_W-1:0]    remove_count,

    // Result channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        event_valid,
    output logic [EV_IN_W-1:0]          event_input,
    output logic                        event_rising,
    output logic [STAMP_W-1:0]          event_time,
    output logic [NEW_W-1:0]            new_events,
    output logic [COUNT_OUT_W-1:0]      logged_count,
    output logic                        log_full
);

    logic [LEVEL_W-1:0] mask_reg;
    logic               mask_we;

    soer_status_t status;
    soer_result_t result;
    soer_result_t result_reg;
    logic         out_valid_reg, out_valid_next;

    logic         start;
    logic         load;

    soer_mem_wr_t     mem_wr;
    logic             mem_re;
    logic [PTR_W-1:0] mem_raddr;
    soer_entry_t      mem_rdata;

    // Register port: zero wait states, only the connected mask lives here.
    assign pready  = 1'b1;
    assign mask_we = psel && penable && pwrite && pready && (paddr == REG_MASK_ADDR);
    assign prdata  = (paddr == REG_MASK_ADDR) ? PDATA_W'(mask_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (mask_we)
        begin
            mask_reg <= pwdata[LEVEL_W-1:0];
        end
    end

    // Take a new item only while the sequencer is idle.
    assign in_stall = !status.idle;
    assign start    = in_valid && !in_stall;

    // Load the output register when the result is ready and the slot is free or draining.
    assign load = status.done && (!out_valid_reg || !out_stall);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the consumer takes it.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_valid  = result_reg.event_valid;
    assign event_input  = result_reg.event_input;
    assign event_rising = result_reg.event_rising;
    assign event_time   = result_reg.event_time;
    assign new_events   = result_reg.new_events;
    assign logged_count = result_reg.logged_count;
    assign log_full     = result_reg.log_full;

    soer_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .take         (load),
        .mask         (mask_reg),
        .mode         (mode),
        .input_levels (input_levels),
        .timestamp    (timestamp),
        .read_offset  (read_offset),
        .remove_count (remove_count),
        .status       (status),
        .result       (result),
        .mem_wr       (mem_wr),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

    soer_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // A finished result waits in the sequencer until the output register takes it.
    `SOER_ASSERT_NEXT(a_done_holds, clk, rst_n, status.done && !load, status.done,
        "finished result dropped before it was loaded")

    // An accepted item keeps the sequencer busy in the cycle after the accept.
    `SOER_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, start, in_stall,
        "sequencer ready again in the cycle after an accept")

    // A valid read implies a non-empty log and no sample count.
    `SOER_ASSERT_NOW(a_read_consistent, clk, rst_n, out_valid && event_valid,
        (logged_count != '0) && (new_events == '0),
        "valid read reported with an empty log or a sample count")

endmodule

`default_nettype wire

// File: rtl/soer_mem.sv
// Event log memory: one write port, one registered read port.
`default_nettype none

module soer_mem
    import soer_pkg::*;
(
    input  wire logic         clk,
    input  wire soer_mem_wr_t wr,
    input  wire logic         re,
    input  wire logic [PTR_W-1:0] raddr,
    output soer_entry_t       rdata
);

    soer_entry_t mem_array [HISTORY_DEPTH];
    soer_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem_array[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: rtl/soer_ctrl.sv
// Sequencer with the shared adder: input scan, log pointers, read and remove steps.
`default_nettype none

module soer_ctrl
    import soer_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic                 take,
    input  wire logic [LEVEL_W-1:0]   mask,
    input  wire logic [MODE_W-1:0]    mode,
    input  wire logic [LEVEL_W-1:0]   input_levels,
    input  wire logic [STAMP_W-1:0]   timestamp,
    input  wire logic [OFFSET_W-1:0]  read_offset,
    input  wire logic [REMOVE_W-1:0]  remove_count,
    output soer_status_t              status,
    output soer_result_t              result,
    output soer_mem_wr_t              mem_wr,
    output logic                      mem_re,
    output logic [PTR_W-1:0]          mem_raddr,
    input  wire soer_entry_t          mem_rdata
);

    soer_state_t state_reg, state_next;

    // Control state.
    logic [LEVEL_W-1:0] last_reg;
    logic [PTR_W-1:0]   wp_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [NEW_W-1:0]   fresh_reg;
    logic               valid_reg;

    // Item payload and scratch.
    logic [MODE_W-1:0]    mode_reg;
    logic [LEVEL_W-1:0]   levels_reg;
    logic [TIME_BITS-1:0] stamp_reg;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [REMOVE_W-1:0]  remove_reg;
    logic [AW-1:0]        acc_reg;
    logic [PTR_W-1:0]     raddr_reg;

    // Shared adder/subtractor.
    logic [AW-1:0] alu_a, alu_b, alu_y;
    logic          alu_sub;

    logic             hit;
    logic             last_idx;
    logic [PTR_W-1:0] wp_inc;
    logic             clear_log;

    assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + AW'(alu_sub);

    assign hit      = mask[idx_reg] && (levels_reg[idx_reg] != last_reg[idx_reg]);
    assign last_idx = (idx_reg == IDX_W'(SCAN_N - 1));
    assign wp_inc   = (wp_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + PTR_W'(1);
    // Remove of count or more entries empties the log.
    assign clear_log = alu_y[AW-1] || (alu_y == '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_SAMPLE: state_next = ST_SCAN;
                        MODE_READ:   state_next = ST_RD_CMP;
                        MODE_REMOVE: state_next = ST_REMOVE;
                        default:     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SCAN:    state_next = last_idx ? ST_DONE : ST_SCAN;
            ST_RD_CMP:  state_next = alu_y[AW-1] ? ST_RD_ADD : ST_DONE;
            ST_RD_ADD:  state_next = ST_RD_WRAP;
            ST_RD_WRAP: state_next = ST_RD_MEM;
            ST_RD_MEM:  state_next = ST_DONE;
            ST_REMOVE:  state_next = ST_DONE;
            ST_DONE:    state_next = take ? ST_IDLE : ST_DONE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Outputs and adder operands.
    always_comb
    begin
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;
        mem_wr.we      = 1'b0;
        mem_wr.addr    = wp_reg;
        mem_wr.data    = '{input_idx: EV_IN_W'(idx_reg),
                           rising:    levels_reg[idx_reg],
                           stamp:     stamp_reg};
        mem_re         = 1'b0;
        status.idle    = 1'b0;
        status.done    = 1'b0;
        case (state_reg)
            ST_IDLE:   status.idle = 1'b1;
            ST_SCAN:   mem_wr.we = hit;
            ST_RD_CMP:
            begin
                // offset - count is negative exactly when the entry exists
                alu_a   = AW'(offset_reg);
                alu_b   = AW'(count_reg);
                alu_sub = 1'b1;
            end
            ST_RD_ADD:
            begin
                alu_a = acc_reg;
                alu_b = AW'(wp_reg);
            end
            ST_RD_WRAP:
            begin
                alu_a = acc_reg;
                alu_b = acc_reg[AW-1] ? AW'(HISTORY_DEPTH) : '0;
            end
            ST_RD_MEM: mem_re = 1'b1;
            ST_REMOVE:
            begin
                alu_a   = AW'(count_reg);
                alu_b   = AW'(remove_reg);
                alu_sub = 1'b1;
            end
            ST_DONE:   status.done = 1'b1;
            default:   status.idle = 1'b0;
        endcase
    end

    assign mem_raddr = raddr_reg;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= '0;
            wp_reg    <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
            fresh_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        idx_reg   <= '0;
                        fresh_reg <= '0;
                        valid_reg <= 1'b0;
                    end
                end
                ST_SCAN:
                begin
                    if (hit)
                    begin
                        wp_reg            <= wp_inc;
                        last_reg[idx_reg] <= levels_reg[idx_reg];
                        fresh_reg         <= fresh_reg + NEW_W'(1);
                        if (count_reg != CNT_W'(HISTORY_DEPTH))
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                        end
                    end
                    if (!last_idx)
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
                ST_RD_CMP: valid_reg <= alu_y[AW-1];
                ST_REMOVE:
                begin
                    if (clear_log)
                    begin
                        count_reg <= '0;
                        wp_reg    <= '0;
                    end
                    else
                    begin
                        count_reg <= alu_y[CNT_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload and scratch registers.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mode_reg   <= mode;
            levels_reg <= input_levels;
            stamp_reg  <= TIME_BITS'(timestamp);
            offset_reg <= read_offset;
            remove_reg <= remove_count;
        end
        if (state_reg == ST_RD_CMP || state_reg == ST_RD_ADD)
        begin
            acc_reg <= alu_y;
        end
        if (state_reg == ST_RD_WRAP)
        begin
            raddr_reg <= alu_y[PTR_W-1:0];
        end
    end

    // Result fields; event fields are zero unless a valid read.
    always_comb
    begin
        result.event_valid  = valid_reg;
        result.event_input  = valid_reg ? mem_rdata.input_idx : '0;
        result.event_rising = valid_reg ? mem_rdata.rising : 1'b0;
        result.event_time   = valid_reg ? STAMP_W'(mem_rdata.stamp) : '0;
        result.new_events   = (mode_reg == MODE_SAMPLE) ? fresh_reg : '0;
        result.logged_count = COUNT_OUT_W'(count_reg);
        result.log_full     = (count_reg == CNT_W'(HISTORY_DEPTH));
    end

endmodule

`default_nettype wire
